>>> sv/lmts_pkg.sv
// shared types, codes and timing constants of the lcd mode timing sequencer
`default_nettype none
package lmts_pkg;

  // display modes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // item actions
  localparam logic ACT_TICK      = 1'b0;
  localparam logic ACT_ENABLE_WR = 1'b1;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 8;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_COMPARE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STAT_SELECT  = 1'd1;

  // timing in machine cycles
  localparam logic [6:0] HBLANK_CYCLES      = 7'd51;
  localparam logic [6:0] OAM_CYCLES         = 7'd20;
  localparam logic [6:0] XFER_CYCLES        = 7'd43;
  localparam logic [6:0] VBLANK_LINE_CYCLES = 7'd114;
  localparam logic [6:0] WRAP_CYCLE         = 7'd1;
  localparam logic [7:0] FIRST_VBLANK_LINE  = 8'd144;
  localparam logic [7:0] LAST_LINE          = 8'd153;

  // stat select bits
  localparam int unsigned SEL_HBLANK  = 0;
  localparam int unsigned SEL_COMPARE = 1;

  typedef struct packed {
    logic       display_on;
    logic [1:0] mode;
    logic [7:0] line;
    logic [6:0] count;
  } timing_state_t;

  typedef struct packed {
    logic [7:0] line_compare;
    logic [1:0] stat_select;
  } timing_cfg_t;

  typedef struct packed {
    logic action;
    logic enable_value;
    logic hblank_dma_active;
  } timing_item_t;

  typedef struct packed {
    logic [1:0] mode;
    logic [7:0] line;
    logic       vblank_irq;
    logic       stat_irq;
    logic       line_render_start;
    logic       frame_done;
    logic       hdma_block_request;
  } timing_result_t;

endpackage
`default_nettype wire

>>> sv/lmts_if.sv
// item channel interfaces of the lcd mode timing sequencer
`default_nettype none
interface lmts_in_if;
  logic valid;
  logic ready;
  logic action;
  logic enable_value;
  logic hblank_dma_active;

  modport source (output valid, action, enable_value, hblank_dma_active, input ready);
  modport sink (input valid, action, enable_value, hblank_dma_active, output ready);
endinterface

interface lmts_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] mode;
  logic [7:0] line;
  logic       vblank_irq;
  logic       stat_irq;
  logic       line_render_start;
  logic       frame_done;
  logic       hdma_block_request;

  modport source (output valid, mode, line, vblank_irq, stat_irq, line_render_start,
                  frame_done, hdma_block_request, input ready);
  modport sink (input valid, mode, line, vblank_irq, stat_irq, line_render_start,
                frame_done, hdma_block_request, output ready);
endinterface
`default_nettype wire

>>> sv/lmts_step.sv
// next-state and result logic for one item of the lcd mode timing sequencer
`default_nettype none
module lmts_step (
  input  wire lmts_pkg::timing_state_t  state_cur,
  input  wire lmts_pkg::timing_cfg_t    cfg,
  input  wire lmts_pkg::timing_item_t   item,
  output lmts_pkg::timing_state_t       state_nxt,
  output lmts_pkg::timing_result_t      result
);

  logic [6:0] count_inc;
  logic [7:0] line_inc;
  logic       cmp_inc;
  logic       cmp_zero;
  logic       vbl;
  logic       stat;
  logic       render;
  logic       hdma;

  assign count_inc = state_cur.count + 7'd1;
  assign line_inc  = state_cur.line + 8'd1;
  // line-compare match when the line counter is loaded
  assign cmp_inc   = (line_inc == cfg.line_compare) && cfg.stat_select[lmts_pkg::SEL_COMPARE];
  assign cmp_zero  = (cfg.line_compare == 8'd0) && cfg.stat_select[lmts_pkg::SEL_COMPARE];

  // mode sequencing
  always_comb begin
    state_nxt = state_cur;
    vbl       = 1'b0;
    stat      = 1'b0;
    render    = 1'b0;
    hdma      = 1'b0;
    if (item.action == lmts_pkg::ACT_ENABLE_WR) begin
      if (!item.enable_value && state_cur.display_on) begin
        state_nxt.line  = 8'd0;
        state_nxt.mode  = lmts_pkg::MODE_HBLANK;
        state_nxt.count = 7'd0;
      end
      state_nxt.display_on = item.enable_value;
    end else if (state_cur.display_on) begin
      state_nxt.count = count_inc;
      case (state_cur.mode)
        lmts_pkg::MODE_HBLANK: begin
          if (count_inc == lmts_pkg::HBLANK_CYCLES) begin
            state_nxt.line  = line_inc;
            state_nxt.count = 7'd0;
            stat            = cmp_inc;
            if (line_inc < lmts_pkg::FIRST_VBLANK_LINE) begin
              state_nxt.mode = lmts_pkg::MODE_OAM;
            end else begin
              state_nxt.mode = lmts_pkg::MODE_VBLANK;
              vbl            = 1'b1;
            end
          end
        end
        lmts_pkg::MODE_VBLANK: begin
          if (count_inc == lmts_pkg::WRAP_CYCLE && state_cur.line == lmts_pkg::LAST_LINE) begin
            state_nxt.line = 8'd0;
            stat           = cmp_zero;
          end else if (count_inc == lmts_pkg::VBLANK_LINE_CYCLES) begin
            state_nxt.count = 7'd0;
            if (state_cur.line == 8'd0) begin
              state_nxt.mode = lmts_pkg::MODE_OAM;
            end else begin
              state_nxt.line = line_inc;
              stat           = cmp_inc;
            end
          end
        end
        lmts_pkg::MODE_OAM: begin
          if (count_inc == lmts_pkg::OAM_CYCLES) begin
            state_nxt.mode  = lmts_pkg::MODE_XFER;
            state_nxt.count = 7'd0;
            render          = 1'b1;
          end
        end
        default: begin
          if (count_inc == lmts_pkg::XFER_CYCLES) begin
            state_nxt.mode  = lmts_pkg::MODE_HBLANK;
            state_nxt.count = 7'd0;
            hdma            = item.hblank_dma_active;
            stat            = cfg.stat_select[lmts_pkg::SEL_HBLANK];
          end
        end
      endcase
    end
  end

  // result item
  always_comb begin
    result.mode               = state_nxt.mode;
    result.line               = state_nxt.line;
    result.vblank_irq         = vbl;
    result.stat_irq           = stat;
    result.line_render_start  = render;
    result.frame_done         = vbl;
    result.hdma_block_request = hdma;
  end

endmodule
`default_nettype wire

>>> sv/lcd_mode_timing_sequencer_unit.sv
// Display mode timing sequencer: each item is a machine-cycle tick or a write of the
// display enable, and yields one result item with mode, line and request pulses. One item
// is accepted every clock cycle unless the result side stalls; its result is offered when it
// moves from the input register into the result register, with the mode/line/count update
// done in the single combinational step between them. Both sides are decoupled by these
// registers, so one more item is taken while a finished result still waits. Configuration
// writes through cfg_we/cfg_index/cfg_data take effect on the next cycle.
`default_nettype none
module lcd_mode_timing_sequencer_unit (
  input  wire                                  clk,
  input  wire                                  rst_n,
  lmts_in_if.sink                              in_ch,
  lmts_out_if.source                           out_ch,
  input  wire                                  cfg_we,
  input  wire [lmts_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  wire [lmts_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic                     in_v_r;
  lmts_pkg::timing_item_t   in_item_r;
  logic                     out_v_r;
  lmts_pkg::timing_result_t out_res_r;
  lmts_pkg::timing_state_t  state_r;
  lmts_pkg::timing_state_t  state_nxt;
  lmts_pkg::timing_cfg_t    cfg_r;
  lmts_pkg::timing_result_t res_nxt;
  logic                     proc_fire;
  logic                     in_fire;

  // handshake
  assign proc_fire   = in_v_r && (!out_v_r || out_ch.ready);
  assign in_ch.ready = !in_v_r || proc_fire;
  assign in_fire     = in_ch.valid && in_ch.ready;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_ch.ready) begin
      in_v_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      in_item_r.action            <= in_ch.action;
      in_item_r.enable_value      <= in_ch.enable_value;
      in_item_r.hblank_dma_active <= in_ch.hblank_dma_active;
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        lmts_pkg::REG_LINE_COMPARE: cfg_r.line_compare <= cfg_data;
        lmts_pkg::REG_STAT_SELECT:  cfg_r.stat_select  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // per-item step
  lmts_step u_step (
    .state_cur (state_r),
    .cfg       (cfg_r),
    .item      (in_item_r),
    .state_nxt (state_nxt),
    .result    (res_nxt)
  );

  // timing state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '0;
    end else if (proc_fire) begin
      state_r <= state_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (!out_v_r || out_ch.ready) begin
      out_v_r <= in_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (proc_fire) begin
      out_res_r <= res_nxt;
    end
  end

  assign out_ch.valid              = out_v_r;
  assign out_ch.mode               = out_res_r.mode;
  assign out_ch.line               = out_res_r.line;
  assign out_ch.vblank_irq         = out_res_r.vblank_irq;
  assign out_ch.stat_irq           = out_res_r.stat_irq;
  assign out_ch.line_render_start  = out_res_r.line_render_start;
  assign out_ch.frame_done         = out_res_r.frame_done;
  assign out_ch.hdma_block_request = out_res_r.hdma_block_request;

endmodule
`default_nettype wire

>>> sv/lmts_checker.sv
// port-level checks of the lcd mode timing sequencer, bound to the top level
`default_nettype none
module lmts_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       out_valid,
  input wire       out_ready,
  input wire [1:0] out_mode,
  input wire [7:0] out_line,
  input wire       out_vblank_irq,
  input wire       out_line_render_start,
  input wire       out_frame_done,
  input wire       out_hdma_block_request
);

  // a pending result item holds until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_mode) && $stable(out_line))
    else $error("result item changed while stalled");

  // vblank entry happens only at the first vblank line, together with frame done
  a_vblank_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_vblank_irq |->
      out_frame_done && out_mode == lmts_pkg::MODE_VBLANK
      && out_line == lmts_pkg::FIRST_VBLANK_LINE)
    else $error("vblank request outside vblank entry");

  // render start only on entering pixel transfer in a visible line
  a_render_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_line_render_start |->
      out_mode == lmts_pkg::MODE_XFER && out_line < lmts_pkg::FIRST_VBLANK_LINE)
    else $error("render start outside pixel transfer");

  // hblank dma block request only on hblank entry
  a_hdma_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hdma_block_request |->
      out_mode == lmts_pkg::MODE_HBLANK && !out_vblank_irq)
    else $error("hdma request outside hblank entry");

endmodule

bind lcd_mode_timing_sequencer_unit lmts_checker u_lmts_checker (
  .clk                    (clk),
  .rst_n                  (rst_n),
  .out_valid              (out_ch.valid),
  .out_ready              (out_ch.ready),
  .out_mode               (out_ch.mode),
  .out_line               (out_ch.line),
  .out_vblank_irq         (out_ch.vblank_irq),
  .out_line_render_start  (out_ch.line_render_start),
  .out_frame_done         (out_ch.frame_done),
  .out_hdma_block_request (out_ch.hdma_block_request)
);
`default_nettype wire

>>> dv/lcd_mode_timing_sequencer_unit_test.sv
// self-checking testbench of the lcd mode timing sequencer with a mode/line tracker
`default_nettype none
module lcd_mode_timing_sequencer_unit_test;

  // tracks display timing state and the results still owed by the block
  class timing_tracker;
    lmts_pkg::timing_state_t  st;
    lmts_pkg::timing_cfg_t    cfg;
    lmts_pkg::timing_result_t owed_results[$];
    int unsigned              errors;
    int unsigned              results_seen;

    function new();
      st = '0;
      cfg = '0;
      errors = 0;
      results_seen = 0;
    endfunction

    function void set_register(logic [lmts_pkg::CFG_IDX_W-1:0] idx,
                               logic [lmts_pkg::CFG_DATA_W-1:0] data);
      case (idx)
        lmts_pkg::REG_LINE_COMPARE: cfg.line_compare = data;
        lmts_pkg::REG_STAT_SELECT:  cfg.stat_select = data[1:0];
        default: ;
      endcase
    endfunction

    // line counter load, returns the line-compare stat request
    function logic load_line(logic [7:0] value);
      st.line = value;
      return (value == cfg.line_compare) && cfg.stat_select[lmts_pkg::SEL_COMPARE];
    endfunction

    function lmts_pkg::timing_result_t advance_timing(lmts_pkg::timing_item_t it);
      lmts_pkg::timing_result_t res;
      res = '0;
      res.mode = st.mode;
      if (it.action == lmts_pkg::ACT_ENABLE_WR) begin
        // turning the display off clears the counters
        if (!it.enable_value && st.display_on) begin
          st.line = '0;
          st.mode = lmts_pkg::MODE_HBLANK;
          st.count = '0;
        end
        st.display_on = it.enable_value;
      end else if (st.display_on) begin
        st.count = st.count + 7'd1;
        case (st.mode)
          lmts_pkg::MODE_HBLANK: begin
            if (st.count == lmts_pkg::HBLANK_CYCLES) begin
              res.stat_irq = load_line(st.line + 8'd1);
              st.count = '0;
              if (st.line < lmts_pkg::FIRST_VBLANK_LINE) begin
                st.mode = lmts_pkg::MODE_OAM;
              end else begin
                st.mode = lmts_pkg::MODE_VBLANK;
                res.vblank_irq = 1'b1;
                res.frame_done = 1'b1;
              end
            end
          end
          lmts_pkg::MODE_VBLANK: begin
            // last line wraps to line 0 on its first tick, still in vblank
            if (st.count == lmts_pkg::WRAP_CYCLE && st.line == lmts_pkg::LAST_LINE) begin
              res.stat_irq = load_line(8'd0);
            end else if (st.count == lmts_pkg::VBLANK_LINE_CYCLES) begin
              st.count = '0;
              if (st.line == 8'd0) begin
                st.mode = lmts_pkg::MODE_OAM;
              end else begin
                res.stat_irq = load_line(st.line + 8'd1);
              end
            end
          end
          lmts_pkg::MODE_OAM: begin
            if (st.count == lmts_pkg::OAM_CYCLES) begin
              st.count = '0;
              st.mode = lmts_pkg::MODE_XFER;
              res.line_render_start = 1'b1;
            end
          end
          default: begin
            if (st.count == lmts_pkg::XFER_CYCLES) begin
              st.count = '0;
              st.mode = lmts_pkg::MODE_HBLANK;
              res.hdma_block_request = it.hblank_dma_active;
              res.stat_irq = cfg.stat_select[lmts_pkg::SEL_HBLANK];
            end
          end
        endcase
      end
      res.mode = st.mode;
      res.line = st.line;
      return res;
    endfunction

    function void note_item(lmts_pkg::timing_item_t it);
      owed_results.push_back(advance_timing(it));
    endfunction

    task report(string msg);
      errors++;
      $display("ERROR: %s", msg);
    endtask

    task compare_field(string name, logic [7:0] got, logic [7:0] want);
      if (got !== want)
        report($sformatf("result %0d %s: got %0h, want %0h", results_seen, name, got, want));
    endtask

    task check_result(lmts_pkg::timing_result_t got);
      lmts_pkg::timing_result_t want;
      if (owed_results.size() == 0) begin
        report($sformatf("result %0d arrived with nothing owed", results_seen));
      end else begin
        want = owed_results.pop_front();
        compare_field("mode", 8'(got.mode), 8'(want.mode));
        compare_field("line", got.line, want.line);
        compare_field("vblank_irq", 8'(got.vblank_irq), 8'(want.vblank_irq));
        compare_field("stat_irq", 8'(got.stat_irq), 8'(want.stat_irq));
        compare_field("line_render_start", 8'(got.line_render_start),
                      8'(want.line_render_start));
        compare_field("frame_done", 8'(got.frame_done), 8'(want.frame_done));
        compare_field("hdma_block_request", 8'(got.hdma_block_request),
                      8'(want.hdma_block_request));
      end
      results_seen++;
    endtask

    task finish_check();
      if (owed_results.size() != 0)
        report($sformatf("%0d results never arrived", owed_results.size()));
    endtask
  endclass

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [lmts_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [lmts_pkg::CFG_DATA_W-1:0] cfg_data;

  lmts_in_if  in_if();
  lmts_out_if out_if();

  timing_tracker tracker;
  int tx_idle_pct;
  int rx_stall_pct;
  int rx_hold;

  lcd_mode_timing_sequencer_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_if),
    .out_ch    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  initial clk = 1'b0;
  always #4 clk = ~clk;

  // run limit
  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

  // receiver: random stalls, plus long hold-offs counted here
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        rx_hold = rx_hold - 1;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  // monitors for accepted items on both channels
  always @(posedge clk) begin
    if (rst_n && in_if.valid && in_if.ready)
      tracker.note_item(lmts_pkg::timing_item_t'({in_if.action, in_if.enable_value,
                                                  in_if.hblank_dma_active}));
    if (rst_n && out_if.valid && out_if.ready)
      tracker.check_result(lmts_pkg::timing_result_t'({out_if.mode, out_if.line,
                                                       out_if.vblank_irq, out_if.stat_irq,
                                                       out_if.line_render_start,
                                                       out_if.frame_done,
                                                       out_if.hdma_block_request}));
  end

  // offer one item, starting and ending at a falling edge, valid left high
  task automatic send_item(logic action, logic enable_value, logic dma);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.action <= action;
    in_if.enable_value <= enable_value;
    in_if.hblank_dma_active <= dma;
    do @(posedge clk); while (!in_if.ready);
    @(negedge clk);
  endtask

  // stop offering and wait for every owed result, then let the pipeline settle
  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (tracker.owed_results.size() != 0) @(negedge clk);
    repeat (6) @(negedge clk);
  endtask

  task automatic write_register(logic [lmts_pkg::CFG_IDX_W-1:0] idx,
                                logic [lmts_pkg::CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    tracker.set_register(idx, data);
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  // one phase: settings, a noisy opening, then a steady run of ticks
  task automatic run_phase(int tx_pct, int rx_pct, logic [7:0] compare_line,
                           logic [1:0] stat_sel, int hold_cycles, bit pause,
                           int frame_ticks);
    int on_ticks;
    wait_drained();
    write_register(lmts_pkg::REG_LINE_COMPARE, compare_line);
    write_register(lmts_pkg::REG_STAT_SELECT, {6'($urandom_range(63)), stat_sel});
    tx_idle_pct = tx_pct;
    rx_stall_pct = rx_pct;
    rx_hold = hold_cycles;
    // noisy opening: frequent enable writes between ticks
    repeat (40) begin
      if ($urandom_range(4) == 0)
        send_item(lmts_pkg::ACT_ENABLE_WR, 1'($urandom_range(1)), 1'($urandom_range(1)));
      else
        send_item(lmts_pkg::ACT_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
    end
    if (pause)
      wait_drained();
    if (!tracker.st.display_on)
      send_item(lmts_pkg::ACT_ENABLE_WR, 1'b1, 1'($urandom_range(1)));
    // display stays on through a run of ticks
    on_ticks = 0;
    while (on_ticks < frame_ticks) begin
      if ($urandom_range(399) == 0) begin
        send_item(lmts_pkg::ACT_ENABLE_WR, 1'b1, 1'($urandom_range(1)));
      end else begin
        send_item(lmts_pkg::ACT_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)));
        on_ticks++;
      end
    end
  endtask

  // main sequence
  initial begin
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_if.valid = 1'b0;
    in_if.action = lmts_pkg::ACT_TICK;
    in_if.enable_value = 1'b0;
    in_if.hblank_dma_active = 1'b0;
    tx_idle_pct = 0;
    rx_stall_pct = 0;
    rx_hold = 0;
    tracker = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // directed: display off ticks, redundant writes, disable mid-line
    write_register(lmts_pkg::REG_LINE_COMPARE, 8'd1);
    write_register(lmts_pkg::REG_STAT_SELECT, 8'd3);
    send_item(lmts_pkg::ACT_TICK, 1'b1, 1'b1);
    send_item(lmts_pkg::ACT_TICK, 1'b0, 1'b0);
    send_item(lmts_pkg::ACT_ENABLE_WR, 1'b0, 1'b1);
    send_item(lmts_pkg::ACT_ENABLE_WR, 1'b1, 1'b0);
    send_item(lmts_pkg::ACT_ENABLE_WR, 1'b1, 1'b1);
    send_item(lmts_pkg::ACT_TICK, 1'b0, 1'b1);
    send_item(lmts_pkg::ACT_TICK, 1'b1, 1'b0);
    send_item(lmts_pkg::ACT_TICK, 1'b0, 1'b0);
    send_item(lmts_pkg::ACT_ENABLE_WR, 1'b0, 1'b0);
    send_item(lmts_pkg::ACT_TICK, 1'b1, 1'b1);
    send_item(lmts_pkg::ACT_ENABLE_WR, 1'b1, 1'b0);
    send_item(lmts_pkg::ACT_TICK, 1'b0, 1'b1);
    send_item(lmts_pkg::ACT_TICK, 1'b1, 1'b1);

    // random phases with varied idling and register settings
    run_phase(0, 0, 8'd0, 2'd2, 400, 1'b0, 100);
    run_phase(48, 0, 8'd255, 2'd1, 0, 1'b1, 100);
    run_phase(0, 48, 8'd153, 2'd3, 0, 1'b0, 100);
    run_phase(14, 14, 8'd144, 2'd3, 0, 1'b0, 100);
    run_phase(0, 0, 8'($urandom_range(153)), 2'd0, 0, 1'b0, 100);

    wait_drained();
    tracker.finish_check();
    if (tracker.errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
`default_nettype wire
